>>> hw/rtl/binary_closing_3x3_assert.svh
// ----------------------------------------------------------------------------
// binary_closing_3x3 assertion macros
// Shared property forms for the port-level checker of the closing block.
// ----------------------------------------------------------------------------
`ifndef BINARY_CLOSING_3X3_ASSERT_SVH
`define BINARY_CLOSING_3X3_ASSERT_SVH

// next-cycle property that must also hold straight out of reset
`define BC3_ASSERT_AFTER(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bc3 check failed");

// next-cycle property checked only outside reset
`define BC3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bc3 check failed");

`endif

>>> hw/rtl/bc3_pkg.sv
// ----------------------------------------------------------------------------
// bc3_pkg
// Types and constants shared by the 3x3 binary closing block.
// ----------------------------------------------------------------------------
package bc3_pkg;

  // fixed field widths
  localparam int ROW_BITS    = 64;
  localparam int INDEX_BITS  = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int WIDTH_BITS  = 7;
  localparam int CFG_BITS    = HEIGHT_BITS;
  localparam int CFG_INDEX_W = 1;

  // defaults and limits
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 4096;
  localparam int COUNTER_LIMIT = 4096;
  localparam int HEIGHT_LIMIT  = (MAX_HEIGHT < COUNTER_LIMIT) ? MAX_HEIGHT : COUNTER_LIMIT;
  localparam int QUEUE_DEPTH   = 4;

  // reset values of the configuration registers
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd64;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 7'd64;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MASK_HEIGHT = 1'b0,
    CFG_MASK_WIDTH  = 1'b1
  } cfg_index_t;

  // which result rows a queued item carries, and its row number
  typedef struct packed {
    logic                  has_a;  // row k-2, regular output
    logic                  has_b;  // row k-1, frame flush
    logic                  has_c;  // row k, last row of the frame
    logic [INDEX_BITS-1:0] k;
  } ctl_t;

  // queue status seen by the back end
  typedef struct packed {
    logic head_valid;
    logic pop;
  } q_hs_t;

endpackage

>>> hw/rtl/bc3_front.sv
// ----------------------------------------------------------------------------
// bc3_front
// Accepts mask rows, keeps the row history, dilates and builds the AND-ed
// row sets that the back end erodes.
// ----------------------------------------------------------------------------
module bc3_front #(
  parameter int MAX_WIDTH = bc3_pkg::MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bc3_pkg::ROW_BITS-1:0]        in_row,
  input  logic [MAX_WIDTH-1:0]                col_mask,
  input  logic [bc3_pkg::INDEX_BITS-1:0]      last_row,
  input  logic                                q_full,
  output logic                                push,
  output bc3_pkg::ctl_t                       push_ctl,
  output logic [MAX_WIDTH-1:0]                row_a,
  output logic [MAX_WIDTH-1:0]                row_b,
  output logic [MAX_WIDTH-1:0]                row_c
);

  localparam int W = MAX_WIDTH;

  function automatic logic [W-1:0] dilate(input logic [W-1:0] v, input logic [W-1:0] m);
    dilate = (v | (v << 1) | (v >> 1)) & m;
  endfunction

  logic [W-1:0] prev_in0, prev_in1, prev_dil0, prev_dil1;
  logic [bc3_pkg::INDEX_BITS-1:0] row_counter;

  logic         accept, k_ge1, k_ge2, k_ge3, flush;
  logic [W-1:0] x, p0, p1, d0, d1, dnew, dlast;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // row position within the frame
  assign k_ge1 = (row_counter != '0);
  assign k_ge2 = (row_counter >= bc3_pkg::INDEX_BITS'(2));
  assign k_ge3 = (row_counter >= bc3_pkg::INDEX_BITS'(3));
  assign flush = (row_counter >= last_row);

  // history, masked with the width now in force
  assign x     = in_row[W-1:0] & col_mask;
  assign p0    = k_ge1 ? (prev_in0 & col_mask) : '0;
  assign p1    = k_ge2 ? (prev_in1 & col_mask) : '0;
  assign d0    = prev_dil0 & col_mask;
  assign d1    = prev_dil1 & col_mask;
  assign dnew  = k_ge1 ? dilate(p1 | p0 | x, col_mask) : '0;
  assign dlast = dilate(p0 | x, col_mask);

  // vertical part of the erosion, rows outside the frame count as set
  assign row_a = (k_ge3 ? d1 : col_mask) & d0 & dnew;
  assign row_b = (k_ge2 ? d0 : col_mask) & dnew & dlast;
  assign row_c = (k_ge1 ? dnew : col_mask) & dlast;

  assign push_ctl.has_a = k_ge2;
  assign push_ctl.has_b = flush & k_ge1;
  assign push_ctl.has_c = flush;
  assign push_ctl.k     = row_counter;
  assign push           = accept & (k_ge2 | flush);

  // row counter, wraps to a new frame after the last row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
    end else if (accept) begin
      if (flush) begin
        row_counter <= '0;
      end else begin
        row_counter <= row_counter + 1'b1;
      end
    end
  end

  // row history
  always_ff @(posedge clk) begin
    if (accept && !flush) begin
      prev_in1 <= prev_in0;
      prev_in0 <= x;
      if (k_ge1) begin
        prev_dil1 <= prev_dil0;
        prev_dil0 <= dnew;
      end
    end
  end

endmodule

>>> hw/rtl/bc3_fifo.sv
// ----------------------------------------------------------------------------
// bc3_fifo
// Small register queue between front and back end, head read fall-through.
// ----------------------------------------------------------------------------
module bc3_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = bc3_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  output logic [DATA_W-1:0] rdata,
  output bc3_pkg::q_hs_t    hs_out,
  input  logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;

  assign full              = (count == CNT_W'(DEPTH));
  assign rdata             = mem[rd_ptr];
  assign hs_out.head_valid = (count != '0);
  assign hs_out.pop        = pop;

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/bc3_back.sv
// ----------------------------------------------------------------------------
// bc3_back
// Walks the result rows of the head item in order, applies the horizontal
// erosion and holds each result in the output register.
// ----------------------------------------------------------------------------
module bc3_back #(
  parameter int MAX_WIDTH = bc3_pkg::MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [MAX_WIDTH-1:0]               col_mask,
  input  bc3_pkg::ctl_t                      head_ctl,
  input  logic [MAX_WIDTH-1:0]               head_a,
  input  logic [MAX_WIDTH-1:0]               head_b,
  input  logic [MAX_WIDTH-1:0]               head_c,
  input  logic                               head_valid,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bc3_pkg::ROW_BITS-1:0]       out_row,
  output logic [bc3_pkg::INDEX_BITS-1:0]     out_row_index,
  output logic                               frame_end
);

  localparam int W = MAX_WIDTH;

  function automatic logic [W-1:0] erode(input logic [W-1:0] v, input logic [W-1:0] m);
    logic [W-1:0] top;
    logic [W-1:0] vm;
    top   = m ^ (m >> 1);
    vm    = v & m;
    erode = vm & ((vm << 1) | W'(1)) & ((vm >> 1) | top) & m;
  endfunction

  logic [2:0] done, done_next;
  logic [2:0] pending, sel, remaining;
  logic       load;
  logic [W-1:0] sel_row;
  logic [bc3_pkg::INDEX_BITS-1:0] sel_index;

  // rows of the head item still to send
  assign pending   = {head_ctl.has_c, head_ctl.has_b, head_ctl.has_a} & ~done
                     & {3{head_valid}};
  assign load      = (~out_valid | ~out_stall) & (|pending);
  assign remaining = pending & ~sel;
  assign pop       = load & (remaining == '0);

  // pick the oldest pending row
  always_comb begin
    if (pending[0]) begin
      sel       = 3'b001;
      sel_row   = head_a;
      sel_index = head_ctl.k - bc3_pkg::INDEX_BITS'(2);
    end else if (pending[1]) begin
      sel       = 3'b010;
      sel_row   = head_b;
      sel_index = head_ctl.k - bc3_pkg::INDEX_BITS'(1);
    end else begin
      sel       = 3'b100;
      sel_row   = head_c;
      sel_index = head_ctl.k;
    end
  end

  always_comb begin
    done_next = done;
    if (pop) begin
      done_next = '0;
    end else if (load) begin
      done_next = done | sel;
    end
  end

  // progress through the head item
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      done <= done_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_row       <= bc3_pkg::ROW_BITS'(erode(sel_row, col_mask));
      out_row_index <= sel_index;
      frame_end     <= sel[2];
    end
  end

endmodule

>>> hw/rtl/binary_closing_3x3.sv
// ----------------------------------------------------------------------------
// binary_closing_3x3
// 3x3 binary closing (dilation, then erosion) of a mask streamed one row
// per item.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  in_row
//   out      from block out_valid/out_stall  out_row, out_row_index, frame_end
//   cfg      to block   cfg_write            cfg_index, cfg_data
//
// One row is accepted per cycle while in_stall is low; result row r
// is queued when row r+2 arrives. The last row of a frame yields up to three
// results, sent one per cycle while out_stall is low. The queue between
// front and back end holds QUEUE_DEPTH items; the input stalls only once
// it is full. Each result passes through the queue and the output register.
// Synchronous reset restores the register defaults and starts a new frame.
// ----------------------------------------------------------------------------
module binary_closing_3x3 #(
  parameter int MAX_WIDTH   = bc3_pkg::MAX_WIDTH,
  parameter int QUEUE_DEPTH = bc3_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bc3_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bc3_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bc3_pkg::ROW_BITS-1:0]        in_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bc3_pkg::ROW_BITS-1:0]        out_row,
  output logic [bc3_pkg::INDEX_BITS-1:0]      out_row_index,
  output logic                                frame_end
);

  localparam int W      = MAX_WIDTH;
  localparam int ENTRY_W = $bits(bc3_pkg::ctl_t) + 3 * W;

  logic [bc3_pkg::HEIGHT_BITS-1:0] mask_height;
  logic [bc3_pkg::WIDTH_BITS-1:0]  mask_width;
  logic [W-1:0]                    col_mask;
  logic [bc3_pkg::INDEX_BITS-1:0]  last_row;

  logic          push, q_full, pop;
  bc3_pkg::ctl_t push_ctl, head_ctl;
  logic [W-1:0]  row_a, row_b, row_c, head_a, head_b, head_c;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  bc3_pkg::q_hs_t q_hs;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_height <= bc3_pkg::HEIGHT_RESET;
      mask_width  <= bc3_pkg::WIDTH_RESET;
    end else if (cfg_write) begin
      case (bc3_pkg::cfg_index_t'(cfg_index))
        bc3_pkg::CFG_MASK_HEIGHT: mask_height <= cfg_data;
        bc3_pkg::CFG_MASK_WIDTH:  mask_width  <= cfg_data[bc3_pkg::WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // column mask, a zero width acts as one column
  for (genvar j = 0; j < W; j++) begin : g_mask
    assign col_mask[j] = (j == 0) || (mask_width > bc3_pkg::WIDTH_BITS'(j));
  end

  // last row index, height clamped to the counter range
  always_comb begin
    if (mask_height == '0) begin
      last_row = '0;
    end else if (mask_height > bc3_pkg::HEIGHT_BITS'(bc3_pkg::HEIGHT_LIMIT)) begin
      last_row = bc3_pkg::INDEX_BITS'(bc3_pkg::HEIGHT_LIMIT - 1);
    end else begin
      last_row = bc3_pkg::INDEX_BITS'(mask_height - 1'b1);
    end
  end

  bc3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_row   (in_row),
    .col_mask (col_mask),
    .last_row (last_row),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .row_a    (row_a),
    .row_b    (row_b),
    .row_c    (row_c)
  );

  assign q_wdata = {push_ctl, row_c, row_b, row_a};
  assign {head_ctl, head_c, head_b, head_a} = q_rdata;

  bc3_fifo #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (q_wdata),
    .full   (q_full),
    .rdata  (q_rdata),
    .hs_out (q_hs),
    .pop    (pop)
  );

  bc3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .col_mask      (col_mask),
    .head_ctl      (head_ctl),
    .head_a        (head_a),
    .head_b        (head_b),
    .head_c        (head_c),
    .head_valid    (q_hs.head_valid),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_row_index (out_row_index),
    .frame_end     (frame_end)
  );

endmodule

>>> hw/rtl/bc3_checker.sv
// ----------------------------------------------------------------------------
// bc3_checker
// Port-level checks for the closing block, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_closing_3x3_assert.svh"

module bc3_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bc3_pkg::ROW_BITS-1:0]    out_row,
  input logic [bc3_pkg::INDEX_BITS-1:0]  out_row_index,
  input logic                            frame_end
);

  // reset empties the output register and the queue
  `BC3_ASSERT_AFTER(a_reset_out_empty, rst, !out_valid)
  `BC3_ASSERT_AFTER(a_reset_in_open, rst, !in_stall)

  // a held result keeps its row, index and end mark
  `BC3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_row) && $stable(out_row_index) && $stable(frame_end))

endmodule

bind binary_closing_3x3 bc3_checker u_bc3_checker (.*);
